// ===== design/ple_pkg.sv =====
`default_nettype none

package ple_pkg;

	// default sizes
	localparam int PLE_CAPACITY   = 16;
	localparam int PLE_DATA_WIDTH = 32;

	// request and result field widths
	localparam int FUNC_W      = 3;
	localparam int VAL_W       = 32;
	localparam int POS_W       = 7;
	localparam int STAT_W      = 2;
	localparam int ENT_W       = 5;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 40;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
	localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_DEL_AT    = 3'd5;
	localparam logic [FUNC_W-1:0] FN_DUMP      = 3'd6;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RESP,
		S_DUMP
	} state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE,
		OP_ROTATE
	} op_t;

	// controller to datapath command
	typedef struct packed {
		op_t               op;
		logic              load;
		logic [STAT_W-1:0] status;
		logic              last;
		logic              show_cell;
	} ple_cmd_t;

endpackage

`default_nettype wire

// ===== design/positional_list_engine.sv =====
// channel  dir  tdata fields (low bit up)                        tlast
// s_axis   in   func[2:0] value[34:3] position[41:35] 0[47:42]   -
// m_axis   out  status[1:0] item_value[33:2] entries[38:34] 0[39] last
//
// an edit or a one-result request is taken on the s_axis handshake; its result sits in
// the result register from the next cycle, and a new request is taken in the
// cycle that result is taken, so one request a cycle with a ready sink
// a dump of n entries gives n results one a cycle while m_tready holds, read from the front cell
// while the cell row rotates; no request is taken until the last one is shown
// reset clears the entry count and the controller; cell contents are not reset
// a stalled result holds in the result register until m_tready
`default_nettype none

module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY   = PLE_CAPACITY,
	parameter int DATA_WIDTH = PLE_DATA_WIDTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// request side: func[2:0] value[34:3] position[41:35], zero pad above
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// result side: status[1:0] item_value[33:2] entries[38:34], zero pad above
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic      [OUT_TDATA_W-1:0] m_tdata,
	output logic                        m_tlast
);

	localparam int FW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	logic [FUNC_W-1:0]     func;
	logic [VAL_W-1:0]      value32;
	logic [POS_W-1:0]      position;
	logic [DATA_WIDTH-1:0] value_dw;
	ple_cmd_t              cmd;
	logic [IW-1:0]         idx;
	logic [FW-1:0]         fill;
	logic [STAT_W-1:0]     out_status;
	logic [VAL_W-1:0]      out_item;
	logic [ENT_W-1:0]      out_entries;
	logic                  out_last;

	// request unpacking
	assign func     = s_tdata[FUNC_W-1:0];
	assign value32  = s_tdata[FUNC_W +: VAL_W];
	assign position = s_tdata[FUNC_W + VAL_W +: POS_W];

	// stored words keep the low DATA_WIDTH bits
	if (DATA_WIDTH <= VAL_W) begin : g_val_trunc
		assign value_dw = value32[DATA_WIDTH-1:0];
	end else begin : g_val_ext
		assign value_dw = {{(DATA_WIDTH - VAL_W){1'b0}}, value32};
	end

	ple_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (func),
		.position (position),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.fill     (fill),
		.cmd      (cmd),
		.idx      (idx)
	);

	ple_datapath #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.idx        (idx),
		.value      (value_dw),
		.fill       (fill),
		.out_status (out_status),
		.out_item   (out_item),
		.out_entries(out_entries),
		.out_last   (out_last)
	);

	// result packing
	assign m_tdata = {1'b0, out_entries, out_item, out_status};
	assign m_tlast = out_last;

endmodule

`default_nettype wire

// ===== design/ple_datapath.sv =====
`default_nettype none

module ple_datapath
	import ple_pkg::*;
#(
	parameter int CAPACITY   = PLE_CAPACITY,
	parameter int DATA_WIDTH = PLE_DATA_WIDTH,
	localparam int FW = $clog2(CAPACITY + 1),
	localparam int IW = $clog2(CAPACITY)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ple_cmd_t              cmd,
	input  wire logic [IW-1:0]         idx,
	input  wire logic [DATA_WIDTH-1:0] value,
	output logic      [FW-1:0]         fill,
	output logic      [STAT_W-1:0]     out_status,
	output logic      [VAL_W-1:0]      out_item,
	output logic      [ENT_W-1:0]      out_entries,
	output logic                       out_last
);

	logic [DATA_WIDTH-1:0] cells_q [CAPACITY];
	logic [DATA_WIDTH-1:0] cells_d [CAPACITY];
	logic [FW-1:0]         fill_q;
	logic [FW-1:0]         fill_d;
	logic [VAL_W-1:0]      cell0_w;

	// front cell as a result word
	if (DATA_WIDTH >= VAL_W) begin : g_trunc
		assign cell0_w = cells_q[0][VAL_W-1:0];
	end else begin : g_ext
		assign cell0_w = {{(VAL_W - DATA_WIDTH){1'b0}}, cells_q[0]};
	end

	always_comb begin
		case (cmd.op)
			OP_INSERT: fill_d = fill_q + FW'(1);
			OP_DELETE: fill_d = fill_q - FW'(1);
			default:   fill_d = fill_q;
		endcase
	end

	// every cell picks itself, a neighbor, the new word or the front cell
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cells_d[i] = cells_q[i];
			case (cmd.op)
				OP_INSERT: begin
					if (IW'(i) == idx)
						cells_d[i] = value;
					else if (IW'(i) > idx)
						cells_d[i] = cells_q[(i == 0) ? 0 : i - 1];
				end
				OP_DELETE: begin
					if (IW'(i) >= idx && i < CAPACITY - 1)
						cells_d[i] = cells_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
				OP_ROTATE: begin
					if (FW'(i + 1) == fill_q)
						cells_d[i] = cells_q[0];
					else if (FW'(i + 1) < fill_q)
						cells_d[i] = cells_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++)
			cells_q[i] <= cells_d[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_status  <= cmd.status;
			out_item    <= cmd.show_cell ? cell0_w : '0;
			out_entries <= ENT_W'(fill_d);
			out_last    <= cmd.last;
		end
	end

	assign fill = fill_q;

endmodule

`default_nettype wire

// ===== design/ple_ctrl.sv =====
`default_nettype none

module ple_ctrl
	import ple_pkg::*;
#(
	parameter int CAPACITY = PLE_CAPACITY,
	localparam int FW = $clog2(CAPACITY + 1),
	localparam int IW = $clog2(CAPACITY),
	localparam int CW = ((FW > POS_W) ? FW : POS_W) + 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [FUNC_W-1:0] func,
	input  wire logic [POS_W-1:0]  position,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [FW-1:0]     fill,
	output ple_cmd_t               cmd,
	output logic      [IW-1:0]     idx
);

	state_t        state_q, state_d;
	logic [FW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] pos_e, fill_e;
	logic          is_full, is_empty, ins_ok, del_ok;
	logic [IW-1:0] pos_idx, fill_idx, back_idx;

	assign pos_e    = CW'(position);
	assign fill_e   = CW'(fill);
	assign is_full  = (fill_e == CW'(CAPACITY));
	assign is_empty = (fill == '0);
	assign ins_ok   = (position != '0) && (pos_e <= fill_e + CW'(1));
	assign del_ok   = (position != '0) && (pos_e <= fill_e);
	assign pos_idx  = IW'(position - POS_W'(1));
	assign fill_idx = IW'(fill);
	assign back_idx = IW'(fill - FW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		cmd.op        = OP_HOLD;
		cmd.load      = 1'b0;
		cmd.status    = ST_OK;
		cmd.last      = 1'b1;
		cmd.show_cell = 1'b0;
		idx           = '0;
		s_tready      = (state_q == S_IDLE) || (state_q == S_RESP && m_tready);
		m_tvalid      = (state_q != S_IDLE);

		case (state_q)
			S_IDLE, S_RESP: begin
				if (state_q == S_RESP && m_tready)
					state_d = S_IDLE;
				if (s_tvalid && s_tready) begin
					cmd.load = 1'b1;
					state_d  = S_RESP;
					case (func)
						FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
							if (is_full) begin
								cmd.status = ST_FULL;
							end else if (func == FN_INS_FRONT) begin
								cmd.op = OP_INSERT;
							end else if (func == FN_INS_BACK) begin
								cmd.op = OP_INSERT;
								idx    = fill_idx;
							end else if (ins_ok) begin
								cmd.op = OP_INSERT;
								idx    = pos_idx;
							end else begin
								cmd.status = ST_BADPOS;
							end
						end
						FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_AT: begin
							if (is_empty) begin
								cmd.status = ST_EMPTY;
							end else if (func == FN_DEL_FRONT) begin
								cmd.op = OP_DELETE;
							end else if (func == FN_DEL_BACK) begin
								cmd.op = OP_DELETE;
								idx    = back_idx;
							end else if (del_ok) begin
								cmd.op = OP_DELETE;
								idx    = pos_idx;
							end else begin
								cmd.status = ST_BADPOS;
							end
						end
						FN_DUMP: begin
							if (!is_empty) begin
								cmd.op        = OP_ROTATE;
								cmd.show_cell = 1'b1;
								cmd.last      = (fill == FW'(1));
								cnt_d         = FW'(1);
								if (fill != FW'(1))
									state_d = S_DUMP;
							end
						end
						default: ;
					endcase
				end
			end
			S_DUMP: begin
				if (m_tready) begin
					cmd.load      = 1'b1;
					cmd.op        = OP_ROTATE;
					cmd.show_cell = 1'b1;
					cmd.last      = (cnt_q + FW'(1) == fill);
					cnt_d         = cnt_q + FW'(1);
					if (cnt_q + FW'(1) == fill)
						state_d = S_RESP;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/ple_checker.sv =====
`default_nettype none

module ple_checker
	import ple_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic                   m_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// dump entries before the last one always report ok
	a_dump_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[STAT_W-1:0] == ST_OK)
		else $error("non-final result with error status");

	// no new request while a dump is still streaming
	a_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("request taken during dump");

	// a taken non-final entry is followed at once by the next one
	a_dump_next: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("dump stream gap");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

`default_nettype wire
